// ===== rtl/sacr_pkg.sv =====
// Package with the types, constants and codes shared by the serial converter reader.
`default_nettype none
package sacr_pkg;

    localparam int NUM_CHIPS = 4;

    localparam int CS_W     = 4;
    localparam int SAMPLE_W = 12;
    localparam int SHIFT_W  = 13;
    localparam int TICK_W   = 16;
    localparam int BIT_W    = 5;

    localparam logic [BIT_W-1:0] CMD_BITS   = 5'd4;
    localparam logic [BIT_W-1:0] TOTAL_BITS = 5'd17;
    localparam logic [BIT_W-1:0] BIT_MODE   = 5'd1;
    localparam logic [BIT_W-1:0] BIT_CHAN   = 5'd2;

    localparam logic [TICK_W-1:0] HALF_RESET  = 16'd100;
    localparam logic [TICK_W-1:0] SETUP_RESET = 16'd20;

    localparam logic CFG_HALF  = 1'b0;
    localparam logic CFG_SETUP = 1'b1;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETUP,
        PH_HIGH,
        PH_LOW,
        PH_TAIL
    } t_phase;

    typedef struct packed {
        logic       opcode;
        logic [1:0] chip_index;
        logic       channel_odd;
        logic       single_ended;
        logic       miso_bit;
    } t_in_item;

    typedef struct packed {
        logic [CS_W-1:0]     cs_lines;
        logic                sclk;
        logic                mosi;
        logic                busy_res;
        logic                done_res;
        logic [SAMPLE_W-1:0] sample;
    } t_out_item;

    typedef struct packed {
        logic [TICK_W-1:0] half_period_ticks;
        logic [TICK_W-1:0] setup_ticks;
    } t_cfg;

endpackage
`default_nettype wire

// ===== rtl/spi_adc_conversion_reader_top.sv =====
// Top level of the serial converter reader: configuration, input and result registers.
//
// Channel  Direction  Valid        Stall        Payload
// in       into block i_in_valid   o_in_stall   i_in_data  (one tick or start item)
// out      from block o_out_valid  i_out_stall  o_out_data (one result per item)
//
// Each item passes from transfer in to result out through the input register and then
// through the frame sequencer into the result register.
// A new item is taken in every cycle while the result side keeps up.
// When the result side stalls, the result register holds and the input register
// holds one more item before the input channel stalls.
// Reset is synchronous and active low; it clears the frame state and loads the
// default half period and setup delay.
`default_nettype none
module spi_adc_conversion_reader_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  sacr_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output sacr_pkg::t_out_item  o_out_data,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_idx,
    input  wire [15:0]           i_cfg_wdata
);
    import sacr_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item w_res;
    logic      w_step;

    assign w_step      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_step;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HALF_RESET;
            r_cfg.setup_ticks       <= SETUP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HALF:  r_cfg.half_period_ticks <= i_cfg_wdata;
                CFG_SETUP: r_cfg.setup_ticks       <= i_cfg_wdata;
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    sacr_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res)
        else $error("sample reported while frame still busy");

    a_select_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.cs_lines != '1 |-> r_out.busy_res)
        else $error("select driven low outside a frame");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire

// ===== rtl/sacr_frame.sv =====
// Frame sequencer: steps one item against the frame state and forms its result.
`default_nettype none
module sacr_frame (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  sacr_pkg::t_in_item   i_item,
    input  sacr_pkg::t_cfg       i_cfg,
    output sacr_pkg::t_out_item  o_res
);
    import sacr_pkg::*;

    t_phase              r_phase, n_phase;
    logic [BIT_W-1:0]    r_bit_index, n_bit_index;
    logic [TICK_W-1:0]   r_tick_count, n_tick_count;
    logic [SHIFT_W-1:0]  r_shift_in, n_shift_in;
    logic [1:0]          r_active_chip, n_active_chip;
    logic                r_latched_mode, n_latched_mode;
    logic                r_latched_channel, n_latched_channel;
    logic                r_clock_level, n_clock_level;
    logic                r_data_level, n_data_level;
    logic [SAMPLE_W-1:0] r_last_sample, n_last_sample;
    logic                w_done;

    logic                w_start;
    logic [TICK_W-1:0]   w_cnt_inc;
    logic                w_half_end;
    logic                w_setup_end;
    logic                w_setup_zero;
    logic [BIT_W-1:0]    w_bit_inc;
    logic [CS_W-1:0]     w_lines;

    assign w_start      = (i_item.opcode == OP_START);
    assign w_cnt_inc    = r_tick_count + 16'd1;
    assign w_half_end   = (w_cnt_inc >= i_cfg.half_period_ticks);
    assign w_setup_end  = (w_cnt_inc >= i_cfg.setup_ticks);
    assign w_setup_zero = (i_cfg.setup_ticks == '0);
    assign w_bit_inc    = r_bit_index + 5'd1;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (w_start) begin
                    n_phase = w_setup_zero ? PH_HIGH : PH_SETUP;
                end
            end
            PH_SETUP: begin
                if (!w_start && w_setup_end) begin
                    n_phase = PH_HIGH;
                end
            end
            PH_HIGH: begin
                if (!w_start && w_half_end) begin
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                if (!w_start && w_half_end) begin
                    n_phase = (w_bit_inc >= TOTAL_BITS) ? PH_TAIL : PH_HIGH;
                end
            end
            PH_TAIL: begin
                if (!w_start && w_half_end) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        n_bit_index       = r_bit_index;
        n_tick_count      = r_tick_count;
        n_shift_in        = r_shift_in;
        n_active_chip     = r_active_chip;
        n_latched_mode    = r_latched_mode;
        n_latched_channel = r_latched_channel;
        n_clock_level     = r_clock_level;
        n_data_level      = r_data_level;
        n_last_sample     = r_last_sample;
        w_done            = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (w_start) begin
                    n_active_chip     = i_item.chip_index;
                    n_latched_channel = i_item.channel_odd;
                    n_latched_mode    = i_item.single_ended;
                    n_data_level      = 1'b1;
                    n_clock_level     = w_setup_zero;
                    n_bit_index       = '0;
                    n_shift_in        = '0;
                    n_tick_count      = '0;
                end
            end
            PH_SETUP: begin
                if (!w_start) begin
                    n_tick_count = w_cnt_inc;
                    if (w_setup_end) begin
                        n_clock_level = 1'b1;
                        n_tick_count  = '0;
                    end
                end
            end
            PH_HIGH: begin
                if (!w_start) begin
                    n_tick_count = w_cnt_inc;
                    if (w_half_end) begin
                        n_clock_level = 1'b0;
                        n_tick_count  = '0;
                    end
                end
            end
            PH_LOW: begin
                if (!w_start) begin
                    n_tick_count = w_cnt_inc;
                    if (w_half_end) begin
                        if (r_bit_index >= CMD_BITS) begin
                            n_shift_in = {r_shift_in[SHIFT_W-2:0], i_item.miso_bit};
                        end
                        n_bit_index = w_bit_inc;
                        if (w_bit_inc == BIT_MODE) begin
                            n_data_level = r_latched_mode;
                        end else if (w_bit_inc == BIT_CHAN) begin
                            n_data_level = r_latched_channel;
                        end else begin
                            n_data_level = 1'b1;
                        end
                        n_tick_count = '0;
                        if (w_bit_inc < TOTAL_BITS) begin
                            n_clock_level = 1'b1;
                        end
                    end
                end
            end
            PH_TAIL: begin
                if (!w_start) begin
                    n_tick_count = w_cnt_inc;
                    if (w_half_end) begin
                        n_last_sample = r_shift_in[SHIFT_W-1:1];
                        n_tick_count  = '0;
                        w_done        = 1'b1;
                    end
                end
            end
            default: begin
                n_tick_count = '0;
            end
        endcase
    end

    always_comb begin
        w_lines = '1;
        if (n_phase != PH_IDLE && n_phase != PH_TAIL && int'(n_active_chip) < NUM_CHIPS) begin
            w_lines[n_active_chip] = 1'b0;
        end
        o_res.cs_lines = w_lines;
        o_res.sclk     = n_clock_level;
        o_res.mosi     = n_data_level;
        o_res.busy_res = (n_phase != PH_IDLE);
        o_res.done_res = w_done;
        o_res.sample   = n_last_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_bit_index       <= '0;
            r_tick_count      <= '0;
            r_shift_in        <= '0;
            r_active_chip     <= '0;
            r_latched_mode    <= 1'b0;
            r_latched_channel <= 1'b0;
            r_clock_level     <= 1'b0;
            r_data_level      <= 1'b1;
            r_last_sample     <= '0;
        end else if (i_step) begin
            r_phase           <= n_phase;
            r_bit_index       <= n_bit_index;
            r_tick_count      <= n_tick_count;
            r_shift_in        <= n_shift_in;
            r_active_chip     <= n_active_chip;
            r_latched_mode    <= n_latched_mode;
            r_latched_channel <= n_latched_channel;
            r_clock_level     <= n_clock_level;
            r_data_level      <= n_data_level;
            r_last_sample     <= n_last_sample;
        end
    end

`ifndef ASSERT_OFF
    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> !r_clock_level && r_data_level)
        else $error("serial clock or data out not at rest while idle");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= TOTAL_BITS)
        else $error("bit index beyond frame length");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_IDLE && !w_start |=> $stable(r_last_sample) && r_phase == PH_IDLE)
        else $error("idle tick changed frame state");
`endif

endmodule
`default_nettype wire
